// File: sv/ibfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfe_pkg
// shared types and constants of the irrigation bus frame encoder
// ----------------------------------------------------------------------------
package ibfe_pkg;

	localparam int MAX_FRAME_BYTES = 16;
	localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
	localparam int FRAME_W         = 8 * MAX_FRAME_BYTES;

	localparam logic [6:0] ZONE_BITS = 7'd120;
	localparam logic [6:0] PROG_BITS = 7'd56;

	localparam logic [119:0] ZONE_BASE = 120'hff_00_00_00_10_00_00_04_00_00_01_00_01_b8_3f;
	localparam logic [55:0]  PROG_BASE = 56'hff_40_03_96_09_bd_7f;

	localparam logic [6:0] ZONE_OFS_A = 7'h17;
	localparam logic [6:0] ZONE_OFS_B = 7'h23;
	localparam logic [6:0] ZONE_OFS_C = 7'h2f;
	localparam logic [5:0] ZONE_MAX   = 6'd48;
	localparam logic [5:0] ZONE_SPLIT = 6'd12;
	localparam logic [7:0] MINS_MAX   = 8'd240;
	localparam logic [2:0] PROG_MAX   = 3'd4;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_PROG  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_ZONE = 3'd1,
		ST_BAD_TIME = 3'd2,
		ST_BAD_PROG = 3'd3,
		ST_BUSY     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_SHORT    = 3'd0,
		REG_LONG     = 3'd1,
		REG_START    = 3'd2,
		REG_RST_HIGH = 3'd3,
		REG_RST_LOW  = 3'd4
	} reg_idx_t;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_RST_HI   = 7'b0000010,
		PH_RST_LO   = 7'b0000100,
		PH_START_HI = 7'b0001000,
		PH_START_LO = 7'b0010000,
		PH_BIT_HI   = 7'b0100000,
		PH_BIT_LO   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic       line_level;
		logic       busy_res;
		logic [2:0] status;
		logic       frame_done;
	} result_t;

endpackage

// File: sv/ibfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfe_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ibfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/irrigation_bus_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrigation_bus_frame_encoder
// one-wire pulse-width frame encoder for irrigation zone and program commands
// ----------------------------------------------------------------------------
// Every input beat is one microsecond of wire time: a tick, or a command that
// also advances the wire timer. The block takes one beat per clock cycle and
// gives one result beat for each through an output register with a one-beat
// skid buffer; in_stall rises only when both are full. An accepted command is
// checked and its frame is swept into the 16-byte frame memory one byte per
// cycle in the background, well ahead of the first frame bit; the next byte is
// prefetched through the memory's registered read port while the current bit
// is on the wire. No clearing pass follows reset. Timing registers sit at byte
// addresses 0x00 to 0x10 on the APB port.
// ----------------------------------------------------------------------------
module irrigation_bus_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [5:0]  zone,
	input  logic [7:0]  minutes,
	input  logic [2:0]  program_req,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        line_level,
	output logic        busy_res,
	output logic [2:0]  status,
	output logic        frame_done,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import ibfe_pkg::*;

	function automatic logic [0:FRAME_W-1] build_frame(input logic is_zone,
		input logic [5:0] zn, input logic [7:0] mins, input logic [2:0] prg);
		logic [0:FRAME_W-1] f;
		logic [6:0]         za;
		logic [6:0]         zb;
		logic [6:0]         zc;
		logic [1:0]         sel;
		logic [5:0]         zm1;
		logic [2:0]         pm1;
		f   = '0;
		za  = 7'(zn) + ZONE_OFS_A;
		zb  = 7'(zn) + ZONE_OFS_B;
		zc  = 7'(zn) + ZONE_OFS_C;
		sel = (zn > ZONE_SPLIT) ? 2'b01 : 2'b10;
		zm1 = zn - 6'd1;
		pm1 = prg - 3'd1;
		if (is_zone) begin
			f[0:119] = ZONE_BASE;
			for (int i = 0; i < 2; i++) begin
				f[9 + i] = sel[i];
			end
			for (int i = 0; i < 7; i++) begin
				f[23 + i] = za[i];
				f[36 + i] = za[i];
				f[49 + i] = zb[i];
				f[62 + i] = zb[i];
				f[75 + i] = zc[i];
				f[88 + i] = zc[i];
			end
			for (int i = 0; i < 4; i++) begin
				f[31 + i]  = mins[i];
				f[44 + i]  = mins[4 + i];
				f[57 + i]  = mins[i];
				f[70 + i]  = mins[4 + i];
				f[83 + i]  = mins[i];
				f[96 + i]  = mins[4 + i];
				f[109 + i] = zm1[i];
			end
		end else begin
			f[0:55] = PROG_BASE;
			for (int i = 0; i < 2; i++) begin
				f[31 + i] = pm1[i];
			end
		end
		return f;
	endfunction

	// configuration registers
	logic [15:0] short_q;
	logic [15:0] long_q;
	logic [15:0] start_q;
	logic [18:0] rst_high_q;
	logic [18:0] rst_low_q;

	// sender state
	phase_t      phase_q;
	logic [18:0] tick_q;
	logic [6:0]  bit_idx_q;
	logic [6:0]  frame_bits_q;
	logic        extra_q;
	logic [7:0]  cur_byte_q;

	// frame sweep
	logic              fill_q;
	logic [ADDR_W-1:0] widx_q;
	logic              is_zone_q;
	logic [5:0]        zone_q;
	logic [7:0]        mins_q;
	logic [2:0]        prog_q;
	logic [0:FRAME_W-1] frame_v;
	logic [ADDR_W-1:0]  raddr;
	logic [7:0]         rdata;

	// output buffer
	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	logic        in_fire;
	logic        out_fire;
	logic        cfg_wr;
	action_t     act;
	logic        cmd;
	logic        busy_now;
	logic        zone_bad;
	status_t     st;
	logic        load;
	phase_t      ph;
	logic [18:0] tick;
	logic [6:0]  bi;
	logic [6:0]  fb;
	logic        ex;
	logic        bit_val;
	logic [18:0] seg_len;
	logic        adv;
	logic        last_bit;
	phase_t      ph_nxt;
	logic [6:0]  bi_nxt;
	logic        done;
	logic        take_byte;
	result_t     res;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q    <= 16'd208;
			long_q     <= 16'd1875;
			start_q    <= 16'd900;
			rst_high_q <= 19'd325000;
			rst_low_q  <= 19'd65000;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_SHORT:    short_q    <= pwdata[15:0];
				REG_LONG:     long_q     <= pwdata[15:0];
				REG_START:    start_q    <= pwdata[15:0];
				REG_RST_HIGH: rst_high_q <= pwdata[18:0];
				REG_RST_LOW:  rst_low_q  <= pwdata[18:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_SHORT:    prdata = 32'(short_q);
			REG_LONG:     prdata = 32'(long_q);
			REG_START:    prdata = 32'(start_q);
			REG_RST_HIGH: prdata = 32'(rst_high_q);
			REG_RST_LOW:  prdata = 32'(rst_low_q);
			default:      prdata = '0;
		endcase
	end

	// command check and step of the wire timer
	always_comb begin
		act      = action_t'(action);
		cmd      = act != ACT_TICK;
		busy_now = phase_q != PH_IDLE;
		zone_bad = (zone == 6'd0) || (zone > ZONE_MAX);
		st       = ST_OK;
		if (cmd) begin
			priority if (busy_now) begin
				st = ST_BUSY;
			end else if (act == ACT_PROG) begin
				st = ((program_req == 3'd0) || (program_req > PROG_MAX)) ? ST_BAD_PROG : ST_OK;
			end else if (zone_bad) begin
				st = ST_BAD_ZONE;
			end else if ((act == ACT_START) && (minutes > MINS_MAX)) begin
				st = ST_BAD_TIME;
			end else begin
				st = ST_OK;
			end
		end
		load = cmd && !busy_now && (st == ST_OK);

		ph   = load ? PH_RST_HI : phase_q;
		tick = load ? 19'd0 : tick_q;
		bi   = load ? 7'd0 : bit_idx_q;
		fb   = load ? ((act == ACT_PROG) ? PROG_BITS : ZONE_BITS) : frame_bits_q;
		ex   = load ? (act != ACT_PROG) : extra_q;

		if (bi < fb) begin
			bit_val = cur_byte_q[3'd7 - bi[2:0]];
		end else begin
			bit_val = (bi == fb) && ex;
		end

		unique case (ph)
			PH_RST_HI:   seg_len = rst_high_q;
			PH_RST_LO:   seg_len = rst_low_q;
			PH_START_HI: seg_len = 19'(start_q);
			PH_START_LO: seg_len = 19'(short_q);
			PH_BIT_HI:   seg_len = bit_val ? 19'(long_q) : 19'(short_q);
			PH_BIT_LO:   seg_len = bit_val ? 19'(short_q) : 19'(long_q);
			default:     seg_len = '0;
		endcase

		adv      = ({1'b0, tick} + 20'd1) >= {1'b0, seg_len};
		last_bit = {1'b0, bi} >= ({1'b0, fb} + {7'd0, ex});
		ph_nxt   = ph;
		bi_nxt   = bi;
		done     = 1'b0;
		if (adv) begin
			unique case (ph)
				PH_RST_HI:   ph_nxt = PH_RST_LO;
				PH_RST_LO:   ph_nxt = PH_START_HI;
				PH_START_HI: ph_nxt = PH_START_LO;
				PH_START_LO: begin
					ph_nxt = PH_BIT_HI;
					bi_nxt = 7'd0;
				end
				PH_BIT_HI:   ph_nxt = PH_BIT_LO;
				PH_BIT_LO: begin
					if (last_bit) begin
						ph_nxt = PH_IDLE;
						bi_nxt = 7'd0;
						done   = 1'b1;
					end else begin
						ph_nxt = PH_BIT_HI;
						bi_nxt = bi + 7'd1;
					end
				end
				default:     ph_nxt = PH_IDLE;
			endcase
		end
		take_byte = adv && ((ph == PH_START_LO) ||
			((ph == PH_BIT_LO) && !last_bit && (bi[2:0] == 3'd7)));

		res.line_level = (ph == PH_RST_HI) || (ph == PH_START_HI) || (ph == PH_BIT_HI);
		res.busy_res   = ph != PH_IDLE;
		res.status     = st;
		res.frame_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_q       <= '0;
			bit_idx_q    <= '0;
			frame_bits_q <= '0;
			extra_q      <= 1'b0;
		end else if (in_fire) begin
			phase_q      <= ph_nxt;
			tick_q       <= (adv || (ph == PH_IDLE)) ? 19'd0 : tick + 19'd1;
			bit_idx_q    <= bi_nxt;
			frame_bits_q <= fb;
			extra_q      <= ex;
		end
	end

	// next byte is always in flight from the frame memory
	assign raddr = ((phase_q == PH_BIT_HI) || (phase_q == PH_BIT_LO)) ?
		bit_idx_q[6:3] + ADDR_W'(1) : '0;

	always_ff @(posedge clk) begin
		if (in_fire && take_byte) begin
			cur_byte_q <= rdata;
		end
		if (in_fire && load) begin
			is_zone_q <= act != ACT_PROG;
			zone_q    <= zone;
			mins_q    <= (act == ACT_START) ? minutes : 8'd0;
			prog_q    <= program_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 1'b0;
			widx_q <= '0;
		end else if (in_fire && load) begin
			fill_q <= 1'b1;
			widx_q <= '0;
		end else if (fill_q) begin
			widx_q <= widx_q + ADDR_W'(1);
			if (widx_q == ADDR_W'(MAX_FRAME_BYTES - 1)) begin
				fill_q <= 1'b0;
			end
		end
	end

	assign frame_v = build_frame(is_zone_q, zone_q, mins_q, prog_q);

	ibfe_ram #(
		.WIDTH(8),
		.DEPTH(MAX_FRAME_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (fill_q),
		.waddr(widx_q),
		.wdata(frame_v[{widx_q, 3'b000} +: 8]),
		.raddr(raddr),
		.rdata(rdata)
	);

	// output register with one skid beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_level = out_q.line_level;
	assign busy_res   = out_q.busy_res;
	assign status     = out_q.status;
	assign frame_done = out_q.frame_done;

endmodule
